// ----- rtl/core/assert_macros.svh -----
// assertion macros shared by the front zone alarm rtl
// no dependencies; taken in by `include where checks are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define LFZA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, ignored while reset is high
`define LFZA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/lfza_pkg.sv -----
// package for the lidar front zone alarm: widths, codes, reset values, stage type
// no dependencies
package lfza_pkg;

   // word field widths
   localparam int IDX_W   = 10;
   localparam int RANGE_W = 16;
   localparam int TRIG_W  = 16;
   localparam int CSR_W   = 16;
   localparam int CSR_INDEX_W = 1;

   // trig values are Q1.14, limits are widened by this many bits
   localparam int TRIG_FRAC = 14;

   // signed product of an unsigned range and a signed trig value
   localparam int PROD_W = RANGE_W + 1 + TRIG_W;

   localparam int SCAN_POINTS_DEFAULT = 1024;

   // request type codes
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SAFE_DISTANCE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_WIDTH    = 1'b1;

   // register reset values, Q6.10 metres
   localparam logic [CSR_W-1:0] SAFE_DISTANCE_RESET = 16'd512;
   localparam logic [CSR_W-1:0] HALF_WIDTH_RESET    = 16'd256;

   // control travelling with a sample down the pipe
   typedef struct packed {
      logic valid;
      logic in_range;
      logic last;
   } lfza_stage_type;

endpackage

// ----- rtl/core/lfza_trig_table.sv -----
// trig table and lookup stage: stores cos/sin per beam, reads them for samples
// depends on lfza_pkg
module lfza_trig_table #(
   parameter int SCAN_POINTS = lfza_pkg::SCAN_POINTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic [lfza_pkg::IDX_W-1:0]         req_beam_index,
   input  logic [lfza_pkg::RANGE_W-1:0]       req_range_value,
   input  logic signed [lfza_pkg::TRIG_W-1:0] req_cos_value,
   input  logic signed [lfza_pkg::TRIG_W-1:0] req_sin_value,
   input  logic                               req_last_sample,
   input  logic                               down_ready,
   output lfza_pkg::lfza_stage_type           s1_stage,
   output logic [lfza_pkg::RANGE_W-1:0]       s1_range,
   output logic signed [lfza_pkg::TRIG_W-1:0] s1_cos,
   output logic signed [lfza_pkg::TRIG_W-1:0] s1_sin
);
   import lfza_pkg::*;

   // only beam indexes below 2**IDX_W are ever reachable
   localparam int MEM_DEPTH = (SCAN_POINTS < (2 ** IDX_W)) ? SCAN_POINTS : (2 ** IDX_W);
   localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
   localparam int CMP_W = ($clog2(SCAN_POINTS + 1) > IDX_W) ? $clog2(SCAN_POINTS + 1) : IDX_W;

   logic [2*TRIG_W-1:0] trig_mem_ff [MEM_DEPTH];
   logic [2*TRIG_W-1:0] trig_rd_ff;

   lfza_stage_type           stage_ff, stage_in;
   logic [RANGE_W-1:0]       range_ff;
   logic                     stage_en;
   logic                     accept;
   logic                     in_range;
   logic [AW-1:0]            addr;

   // stage advances when empty or when the next stage takes its word
   assign stage_en  = !stage_ff.valid || down_ready;
   assign req_ready = stage_en;
   assign accept    = req_valid && req_ready;
   assign in_range  = CMP_W'(req_beam_index) < CMP_W'(SCAN_POINTS);
   assign addr      = req_beam_index[AW-1:0];

   // table write on load words, registered read on sample words
   always_ff @(posedge clock) begin
      if (accept && (req_type == REQ_LOAD) && in_range) begin
         trig_mem_ff[addr] <= {req_cos_value, req_sin_value};
      end
      if (stage_en) begin
         trig_rd_ff <= trig_mem_ff[addr];
      end
   end

   // next lookup stage control
   always_comb begin
      stage_in.valid    = accept && (req_type == REQ_SAMPLE);
      stage_in.in_range = in_range;
      stage_in.last     = req_last_sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (stage_en) begin
         stage_ff <= stage_in;
      end
   end

   // range travels alongside the read data
   always_ff @(posedge clock) begin
      if (stage_en) begin
         range_ff <= req_range_value;
      end
   end

   assign s1_stage = stage_ff;
   assign s1_range = range_ff;
   assign s1_cos   = $signed(trig_rd_ff[2*TRIG_W-1:TRIG_W]);
   assign s1_sin   = $signed(trig_rd_ff[TRIG_W-1:0]);

endmodule

// ----- rtl/core/lfza_project.sv -----
// projection stage: x = r*cos and y = r*sin, registered products
// depends on lfza_pkg
module lfza_project (
   input  logic                               clock,
   input  logic                               reset,
   input  lfza_pkg::lfza_stage_type           s1_stage,
   input  logic [lfza_pkg::RANGE_W-1:0]       s1_range,
   input  logic signed [lfza_pkg::TRIG_W-1:0] s1_cos,
   input  logic signed [lfza_pkg::TRIG_W-1:0] s1_sin,
   output logic                               up_ready,
   input  logic                               down_ready,
   output lfza_pkg::lfza_stage_type           s2_stage,
   output logic signed [lfza_pkg::PROD_W-1:0] s2_x,
   output logic signed [lfza_pkg::PROD_W-1:0] s2_y
);
   import lfza_pkg::*;

   lfza_stage_type          stage_ff;
   logic signed [PROD_W-1:0] x_ff, x_in;
   logic signed [PROD_W-1:0] y_ff, y_in;
   logic signed [RANGE_W:0]  range_s;
   logic                     stage_en;

   assign stage_en = !stage_ff.valid || down_ready;
   assign up_ready = stage_en;

   // exact products, range treated as a non-negative signed value
   assign range_s = $signed({1'b0, s1_range});
   assign x_in    = PROD_W'(range_s) * PROD_W'(s1_cos);
   assign y_in    = PROD_W'(range_s) * PROD_W'(s1_sin);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else if (stage_en) begin
         stage_ff <= s1_stage;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign s2_stage = stage_ff;
   assign s2_x     = x_ff;
   assign s2_y     = y_ff;

endmodule

// ----- rtl/core/lfza_zone_check.sv -----
// zone check: box test, scan hit state, limit registers and result register
// depends on lfza_pkg
module lfza_zone_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [lfza_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lfza_pkg::CSR_W-1:0]         csr_data,
   input  lfza_pkg::lfza_stage_type           s2_stage,
   input  logic signed [lfza_pkg::PROD_W-1:0] s2_x,
   input  logic signed [lfza_pkg::PROD_W-1:0] s2_y,
   output logic                               up_ready,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_alarm_any,
   output logic                               rsp_alarm_left,
   output logic                               rsp_alarm_right
);
   import lfza_pkg::*;

   logic [CSR_W-1:0]         safe_distance_ff, half_width_ff;
   logic                     hit_seen_ff, hit_left_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     any_ff, left_ff, right_ff;
   logic signed [PROD_W-1:0] lim_x, lim_y, neg_lim_y;
   logic                     out_free, take, hit;
   logic                     seen_new, left_new;

   // limit registers
   always_ff @(posedge clock) begin
      if (reset) begin
         safe_distance_ff <= SAFE_DISTANCE_RESET;
         half_width_ff    <= HALF_WIDTH_RESET;
      end else if (csr_write) begin
         if (csr_index == CSR_SAFE_DISTANCE) begin
            safe_distance_ff <= csr_data;
         end else begin
            half_width_ff <= csr_data;
         end
      end
   end

   // limits widened to the product scale
   assign lim_x     = $signed(PROD_W'({safe_distance_ff, {TRIG_FRAC{1'b0}}}));
   assign lim_y     = $signed(PROD_W'({half_width_ff, {TRIG_FRAC{1'b0}}}));
   assign neg_lim_y = -lim_y;

   // a word with no result always passes; a scan end needs the result register
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign up_ready = !s2_stage.last || out_free;
   assign take     = s2_stage.valid && up_ready;

   // box test, strict on every side
   assign hit = s2_stage.in_range && !s2_x[PROD_W-1] && (s2_x != '0) &&
                (s2_x < lim_x) && (s2_y > neg_lim_y) && (s2_y < lim_y);

   // latest hit decides the side
   assign seen_new = hit_seen_ff || hit;
   assign left_new = hit ? !s2_y[PROD_W-1] : hit_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_seen_ff <= 1'b0;
         hit_left_ff <= 1'b0;
      end else if (take) begin
         if (s2_stage.last) begin
            hit_seen_ff <= 1'b0;
            hit_left_ff <= 1'b0;
         end else begin
            hit_seen_ff <= seen_new;
            hit_left_ff <= left_new;
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (take && s2_stage.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && s2_stage.last) begin
         any_ff   <= seen_new;
         left_ff  <= seen_new && left_new;
         right_ff <= seen_new && !left_new;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_alarm_any   = any_ff;
   assign rsp_alarm_left  = left_ff;
   assign rsp_alarm_right = right_ff;

endmodule

// ----- rtl/core/lidar_front_zone_alarm_core.sv -----
// lidar front zone alarm, top level
// depends on lfza_pkg, lfza_trig_table, lfza_project, lfza_zone_check, assert_macros.svh
//
// Request words either load the cos/sin table entry of one beam (req_type load)
// or carry one range reading (req_type sample). Each sample is projected to
// x = r*cos, y = r*sin and tested against the box 0 < x < safe_distance,
// |y| < half_width. The latest hit of a scan sets the side (y >= 0 is left).
// A sample with req_last_sample set sends one response word with the three
// alarm flags and clears the scan state; no other word gives a response.
// The user must write the limit registers through csr_write/csr_index/csr_data
// only while no word is in flight; the block does not enforce this.
// Throughput: one word per cycle while no held response stalls the pipe. A scan
// end passes through the table read, multiply and check registers to the response.
// Reset clears the pipe, the scan state and the response, and restores the
// limit registers; the table keeps no reset value and must be loaded first.
// When rsp_ready is low the held response stalls only the scan-end word
// behind it; other words keep flowing until the stages in front fill up.
`include "assert_macros.svh"

module lidar_front_zone_alarm_core #(
   parameter int SCAN_POINTS = lfza_pkg::SCAN_POINTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_type,
   input  logic [lfza_pkg::IDX_W-1:0]         req_beam_index,
   input  logic [lfza_pkg::RANGE_W-1:0]       req_range_value,
   input  logic signed [lfza_pkg::TRIG_W-1:0] req_cos_value,
   input  logic signed [lfza_pkg::TRIG_W-1:0] req_sin_value,
   input  logic                               req_last_sample,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_alarm_any,
   output logic                               rsp_alarm_left,
   output logic                               rsp_alarm_right,
   // register write port
   input  logic                               csr_write,
   input  logic [lfza_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [lfza_pkg::CSR_W-1:0]         csr_data
);
   import lfza_pkg::*;

   lfza_stage_type           s1_stage, s2_stage;
   logic [RANGE_W-1:0]       s1_range;
   logic signed [TRIG_W-1:0] s1_cos, s1_sin;
   logic signed [PROD_W-1:0] s2_x, s2_y;
   logic                     proj_ready, check_ready;

   // table and lookup stage
   lfza_trig_table #(
      .SCAN_POINTS (SCAN_POINTS)
   ) u_table (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_beam_index  (req_beam_index),
      .req_range_value (req_range_value),
      .req_cos_value   (req_cos_value),
      .req_sin_value   (req_sin_value),
      .req_last_sample (req_last_sample),
      .down_ready      (proj_ready),
      .s1_stage        (s1_stage),
      .s1_range        (s1_range),
      .s1_cos          (s1_cos),
      .s1_sin          (s1_sin)
   );

   // multiply stage
   lfza_project u_project (
      .clock      (clock),
      .reset      (reset),
      .s1_stage   (s1_stage),
      .s1_range   (s1_range),
      .s1_cos     (s1_cos),
      .s1_sin     (s1_sin),
      .up_ready   (proj_ready),
      .down_ready (check_ready),
      .s2_stage   (s2_stage),
      .s2_x       (s2_x),
      .s2_y       (s2_y)
   );

   // box test and response register
   lfza_zone_check u_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .s2_stage        (s2_stage),
      .s2_x            (s2_x),
      .s2_y            (s2_y),
      .up_ready        (check_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_alarm_any   (rsp_alarm_any),
      .rsp_alarm_left  (rsp_alarm_left),
      .rsp_alarm_right (rsp_alarm_right)
   );

   // an accepted sample reaches the lookup stage on the next cycle
   `LFZA_ASSERT_NEXT(a_sample_enters, clock, reset, req_valid && req_ready && (req_type == REQ_SAMPLE), s1_stage.valid)

   // a scan end blocked by a held response stays in the multiply stage
   `LFZA_ASSERT_NEXT(a_scan_end_held, clock, reset, s2_stage.valid && s2_stage.last && rsp_valid && !rsp_ready, s2_stage.valid && s2_stage.last)

   // a response names one side at most, and any alarm names a side
   `LFZA_ASSERT_IMPLY(a_rsp_flags, clock, reset, rsp_valid, !(rsp_alarm_left && rsp_alarm_right) && (rsp_alarm_any == (rsp_alarm_left || rsp_alarm_right)))

endmodule
